FILE: rtl/core/pcf_pkg.sv
// Shared types, codes and small helpers for the Playfair digraph cipher.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcf_pkg;

	localparam int LetterW = 5;
	localparam int Letters = 26;
	localparam int Cells = 25;

	localparam logic [LetterW-1:0] LETTER_I = 5'd8;
	localparam logic [LetterW-1:0] LETTER_J = 5'd9;
	localparam logic [LetterW-1:0] LETTER_X = 5'd23;
	localparam logic [LetterW-1:0] LETTER_LIMIT = 5'd26;
	localparam logic [LetterW-1:0] CELLS_FULL = 5'd25;
	localparam logic [LetterW-1:0] LAST_LETTER = 5'd25;

	// used flags after reset: only j is marked
	localparam logic [Letters-1:0] USED_RESET = 26'(1) << LETTER_J;

	// input kinds
	localparam logic [1:0] KIND_KEY = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_MSG = 2'd2;
	localparam logic [1:0] KIND_RSVD = 2'd3;

	// configuration register indexes
	localparam logic [0:0] REG_DECRYPT = 1'b0;
	localparam logic [0:0] REG_FILLER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_POS,
		ST_SQ,
		ST_EMX,
		ST_EMY
	} pcf_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic fill_step;
		logic rd_pos;
		logic rd_sq;
		logic emit_x;
		logic emit_y;
		logic final_word;
		logic sel;
	} pcf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       start_fill;
		logic [1:0] npairs;
		logic       two_pairs;
		logic       fill_done;
		logic       out_free;
		logic       key_ready;
	} pcf_stat_t;

	function automatic logic [LetterW-1:0] fold(input logic [LetterW-1:0] v);
		return (v == LETTER_J) ? LETTER_I : v;
	endfunction

	function automatic logic [2:0] inc5(input logic [2:0] v);
		return (v == 3'd4) ? 3'd0 : v + 3'd1;
	endfunction

	function automatic logic [2:0] dec5(input logic [2:0] v);
		return (v == 3'd0) ? 3'd4 : v - 3'd1;
	endfunction

	// row-major cell address: row*5 + col
	function automatic logic [LetterW-1:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
		return {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: controller plus datapath.
// Depends on pcf_pkg, pcf_ctrl and pcf_datapath.
//
//  channel  | handshake              | words
//  ---------+------------------------+----------------------------
//  item     | item_valid/item_stall  | kind, letter, last
//  result   | res_valid/res_stall    | out_letter, run_end
//  config   | cfg_we (no wait)       | cfg_index, cfg_data
//
// One item at a time. Key letters and ignored items are done once accepted;
// key end then runs the fill, one alphabet letter tried per cycle. A message
// item, once accepted, runs a position read, a square read and two words out
// through the output register per digraph (zero to two); res_stall can hold it.
// Reset clears control state only; the square and position memories need no
// clearing pass since they are always written before they are read.
`default_nettype none

module playfair_digraph_cipher (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [1:0]                  kind,
	input  wire logic [pcf_pkg::LetterW-1:0] letter,
	input  wire logic                        last,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic [pcf_pkg::LetterW-1:0]      out_letter,
	output logic                             run_end,
	input  wire logic                        cfg_we,
	input  wire logic [0:0]                  cfg_index,
	input  wire logic [pcf_pkg::LetterW-1:0] cfg_data
);
	import pcf_pkg::*;

	pcf_cmd_t  cmd;
	pcf_stat_t stat;

	pcf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	pcf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.kind       (kind),
		.letter     (letter),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_letter (out_letter),
		.run_end    (run_end),
		.res_valid  (res_valid),
		.res_stall  (res_stall)
	);

	// no datapath work while the item side is open
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall |-> !(cmd.rd_pos || cmd.rd_sq || cmd.emit_x || cmd.emit_y || cmd.fill_step))
		else $error("datapath busy while accepting items");

	// digraphs are only looked up once the key square is complete
	a_key_before_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_pos |-> stat.key_ready)
		else $error("position lookup before key ready");

	// a new result word only appears after an emit command
	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd.emit_x || cmd.emit_y))
		else $error("result word without emit");

	// emit never overwrites a word still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_x || cmd.emit_y) |-> (!res_valid || !res_stall))
		else $error("emit into a stalled output register");

endmodule

`default_nettype wire

FILE: rtl/core/pcf_ctrl.sv
// Controller state machine for the Playfair cipher: sequences key fill and
// the read/transform/emit steps of each digraph. Depends on pcf_pkg.
`default_nettype none

module pcf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire pcf_pkg::pcf_stat_t stat,
	output pcf_pkg::pcf_cmd_t      cmd
);
	import pcf_pkg::*;

	pcf_state_t state_q, state_d;
	logic       sel_q, sel_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.sel = sel_q;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.accept = item_valid;
				if (item_valid) begin
					sel_d = 1'b0;
					if (stat.start_fill) begin
						state_d = ST_FILL;
					end else if (stat.npairs != 2'd0) begin
						state_d = ST_POS;
					end
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_POS: begin
				cmd.rd_pos = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.rd_sq = 1'b1;
				state_d = ST_EMX;
			end
			ST_EMX: begin
				if (stat.out_free) begin
					cmd.emit_x = 1'b1;
					state_d = ST_EMY;
				end
			end
			ST_EMY: begin
				cmd.final_word = !(stat.two_pairs && !sel_q);
				if (stat.out_free) begin
					cmd.emit_y = 1'b1;
					if (stat.two_pairs && !sel_q) begin
						sel_d = 1'b1;
						state_d = ST_POS;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/pcf_datapath.sv
// Datapath for the Playfair cipher: key square and position memories, used
// flags, pending letter, digraph rules and the output register. Uses pcf_pkg.
`default_nettype none

module pcf_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pcf_pkg::pcf_cmd_t           cmd,
	output pcf_pkg::pcf_stat_t               stat,
	input  wire logic [1:0]                  kind,
	input  wire logic [pcf_pkg::LetterW-1:0] letter,
	input  wire logic                        last,
	input  wire logic                        cfg_we,
	input  wire logic [0:0]                  cfg_index,
	input  wire logic [pcf_pkg::LetterW-1:0] cfg_data,
	output logic [pcf_pkg::LetterW-1:0]      out_letter,
	output logic                             run_end,
	output logic                             res_valid,
	input  wire logic                        res_stall
);
	import pcf_pkg::*;

	// configuration
	logic               decrypt_q;
	logic [LetterW-1:0] filler_q;

	// key state
	logic [LetterW-1:0] sq_mem [Cells];
	logic [5:0]         pos_mem [Letters];
	logic [Letters-1:0] used_q;
	logic [LetterW-1:0] cells_q;
	logic [2:0]         row_q, col_q;
	logic               key_ready_q;
	logic [LetterW-1:0] k_q;

	// message state
	logic               pend_valid_q;
	logic [LetterW-1:0] pend_q;
	logic [LetterW-1:0] a0_q, b0_q, a1_q, b1_q;
	logic               two_q;

	// read pipeline
	logic [5:0]         pa_s1, pb_s1;
	logic [LetterW-1:0] x_s2, y_s2;

	// output register
	logic               res_valid_q;
	logic               run_end_q;
	logic [LetterW-1:0] out_letter_q;

	// item decode
	logic               legal, is_key, is_end, is_msg;
	logic [LetterW-1:0] v, fill;
	logic               differ;
	logic [1:0]         np;
	logic [LetterW-1:0] a0_d, b0_d;
	logic               pend_valid_d;

	always_comb begin
		legal = (letter < LETTER_LIMIT) && (kind != KIND_RSVD);
		v = fold(letter);
		is_key = legal && (kind == KIND_KEY);
		is_end = legal && (kind == KIND_END);
		is_msg = legal && (kind == KIND_MSG) && key_ready_q;
		fill = (filler_q >= LETTER_LIMIT) ? LETTER_X : fold(filler_q);
		differ = pend_valid_q && (pend_q != v);
		a0_d = pend_q;
		b0_d = v;
		if (decrypt_q) begin
			np = {1'b0, pend_valid_q};
			pend_valid_d = !pend_valid_q && !last;
		end else if (differ) begin
			np = 2'd1;
			pend_valid_d = 1'b0;
		end else begin
			np = {1'b0, pend_valid_q} + {1'b0, last};
			pend_valid_d = !last;
			b0_d = fill;
			if (!pend_valid_q) begin
				a0_d = v;
			end
		end
	end

	// shared place unit, with the clear of a new key folded in
	logic               clr_key, place_en, do_place;
	logic [LetterW-1:0] place_v;
	logic [Letters-1:0] used_base;
	logic [LetterW-1:0] cells_base;
	logic [2:0]         row_base, col_base;

	always_comb begin
		clr_key = cmd.accept && is_key && key_ready_q;
		used_base = clr_key ? USED_RESET : used_q;
		cells_base = clr_key ? '0 : cells_q;
		row_base = clr_key ? '0 : row_q;
		col_base = clr_key ? '0 : col_q;
		place_en = (cmd.accept && is_key) || cmd.fill_step;
		place_v = cmd.fill_step ? k_q : v;
		do_place = place_en && !used_base[place_v] && (cells_base != CELLS_FULL);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
			filler_q <= LETTER_X;
			used_q <= USED_RESET;
			cells_q <= '0;
			row_q <= '0;
			col_q <= '0;
			key_ready_q <= 1'b0;
			k_q <= '0;
			pend_valid_q <= 1'b0;
			pend_q <= '0;
			two_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DECRYPT: decrypt_q <= cfg_data[0];
					REG_FILLER:  filler_q <= cfg_data;
					default:     ;
				endcase
			end
			if (place_en) begin
				used_q <= used_base | (do_place ? (26'(1) << place_v) : '0);
				cells_q <= do_place ? cells_base + 5'd1 : cells_base;
				if (do_place) begin
					col_q <= (col_base == 3'd4) ? 3'd0 : col_base + 3'd1;
					row_q <= (col_base == 3'd4) ? row_base + 3'd1 : row_base;
				end else begin
					col_q <= col_base;
					row_q <= row_base;
				end
			end
			if (clr_key) begin
				key_ready_q <= 1'b0;
				pend_valid_q <= 1'b0;
				pend_q <= '0;
			end
			if (cmd.accept && is_end) begin
				k_q <= '0;
				pend_valid_q <= 1'b0;
				pend_q <= '0;
			end
			if (cmd.fill_step) begin
				k_q <= k_q + 5'd1;
				if (k_q == LAST_LETTER) begin
					key_ready_q <= 1'b1;
				end
			end
			if (cmd.accept && is_msg) begin
				pend_valid_q <= pend_valid_d;
				pend_q <= pend_valid_d ? v : '0;
				two_q <= np == 2'd2;
			end
			// output register
			if (cmd.emit_x || cmd.emit_y) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// pair operands
	always_ff @(posedge clk) begin
		if (cmd.accept && is_msg) begin
			a0_q <= a0_d;
			b0_q <= b0_d;
			a1_q <= v;
			b1_q <= fill;
		end
	end

	// key memories, one write per cycle
	always_ff @(posedge clk) begin
		if (do_place) begin
			sq_mem[cells_base] <= place_v;
			pos_mem[place_v] <= {row_base, col_base};
		end
	end

	// position lookup, registered
	always_ff @(posedge clk) begin
		if (cmd.rd_pos) begin
			pa_s1 <= pos_mem[cmd.sel ? a1_q : a0_q];
			pb_s1 <= pos_mem[cmd.sel ? b1_q : b0_q];
		end
	end

	// digraph rules: row, column, rectangle
	logic [2:0]         r1, c1, r2, c2, sr1, sc1, sr2, sc2;
	logic [LetterW-1:0] ax, ay;

	always_comb begin
		r1 = pa_s1[5:3];
		c1 = pa_s1[2:0];
		r2 = pb_s1[5:3];
		c2 = pb_s1[2:0];
		sr1 = decrypt_q ? dec5(r1) : inc5(r1);
		sc1 = decrypt_q ? dec5(c1) : inc5(c1);
		sr2 = decrypt_q ? dec5(r2) : inc5(r2);
		sc2 = decrypt_q ? dec5(c2) : inc5(c2);
		if (r1 == r2) begin
			ax = cell_addr(r1, sc1);
			ay = cell_addr(r2, sc2);
		end else if (c1 == c2) begin
			ax = cell_addr(sr1, c1);
			ay = cell_addr(sr2, c2);
		end else begin
			ax = cell_addr(r1, c2);
			ay = cell_addr(r2, c1);
		end
	end

	// square lookup, registered
	always_ff @(posedge clk) begin
		if (cmd.rd_sq) begin
			x_s2 <= sq_mem[ax];
			y_s2 <= sq_mem[ay];
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit_x) begin
			out_letter_q <= x_s2;
			run_end_q <= 1'b0;
		end else if (cmd.emit_y) begin
			out_letter_q <= y_s2;
			run_end_q <= cmd.final_word;
		end
	end

	assign out_letter = out_letter_q;
	assign run_end = run_end_q;
	assign res_valid = res_valid_q;

	always_comb begin
		stat.start_fill = is_end;
		stat.npairs = is_msg ? np : 2'd0;
		stat.two_pairs = two_q;
		stat.fill_done = k_q == LAST_LETTER;
		stat.out_free = !res_valid_q || !res_stall;
		stat.key_ready = key_ready_q;
	end

endmodule

`default_nettype wire
